[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on the rising edge of i_clk, off while in reset.
`define AM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define AM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/jp2bms_pkg.sv]
`default_nettype none

package jp2bms_pkg;

    localparam int unsigned OFFSET_BITS = 32;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [31:0] TYPE_XML  = 32'h786D6C20;
    localparam logic [31:0] TYPE_UUID = 32'h75756964;

    localparam int unsigned K_XML  = 0;
    localparam int unsigned K_XMP  = 1;
    localparam int unsigned K_EXIF = 2;
    localparam int unsigned NUM_KINDS = 3;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_UUID    = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        CAUSE_CLEAN = 2'd0,
        CAUSE_CUT   = 2'd1,
        CAUSE_SHORT = 2'd2
    } t_cause;

    // Row 0: XMP, rows 1 and 2: EXIF.
    function automatic logic [7:0] uuid_byte(input logic [1:0] row, input logic [3:0] k);
        logic [127:0] line;
        begin
            case (row)
                2'd0: line = 128'hBE7ACFCB97A942E89C71999491E3AFAC;
                2'd1: line = 128'h4A706754696666457869662D3E4A5032;
                2'd2: line = 128'h0537CDAB9D0C4431A72AFA561F2A113E;
                default: line = '0;
            endcase
            uuid_byte = line[127 - 8*k -: 8];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/jp2_box_metadata_scanner.sv]
// JP2 box scanner: locates the payloads of the last 'xml ' box and the last
// XMP and EXIF 'uuid' boxes in a JP2 file streamed one byte per transaction.
// Input channel: i_in_valid / o_in_ready carry i_data_byte and i_last_byte.
// One byte is taken per cycle while o_in_ready is high, back to back.
// Output channel: o_out_valid / i_out_ready carry one report per file, made
// only for the byte flagged by i_last_byte: found flags, payload offsets and
// lengths clamped to the stream end, and the cause that ended the scan.
// The report passes the staging register, then the output register, to o_out_valid.
// Throughput: one byte per cycle while o_in_ready is high, as the box header and
// position update loop handles each byte; a report alone does not stall the input.
// The byte after a last byte starts a new file with all state cleared.
// Reset (synchronous, active low) clears the scanner state and both report
// stages. When the receiver stalls, the report holds in the output register,
// a second report may wait in the staging register behind it, and
// o_in_ready drops only while both are full.
`default_nettype none

module jp2_box_metadata_scanner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_xml_found,
    output logic [31:0]      o_xml_offset,
    output logic [31:0]      o_xml_length,
    output logic             o_xmp_found,
    output logic [31:0]      o_xmp_offset,
    output logic [31:0]      o_xmp_length,
    output logic             o_exif_found,
    output logic [31:0]      o_exif_offset,
    output logic [31:0]      o_exif_length,
    output logic [1:0]       o_stop_cause
);

    localparam int unsigned OB = jp2bms_pkg::OFFSET_BITS;
    localparam int unsigned NK = jp2bms_pkg::NUM_KINDS;

    jp2bms_pkg::t_phase r_phase, n_phase;
    jp2bms_pkg::t_cause r_cause, n_cause;
    logic [OB-1:0] r_byte_pos, n_byte_pos;
    logic [OB-1:0] r_box_start, n_box_start;
    logic [4:0]    r_hdr_idx, n_hdr_idx;
    logic [63:0]   r_decl, n_decl;
    logic [31:0]   r_type, n_type;
    logic          r_runs, n_runs;
    logic [2:0]    r_flags, n_flags;
    logic [OB-1:0] r_kstart [NK];
    logic [OB-1:0] n_kstart [NK];
    logic [OB-1:0] r_kend [NK];
    logic [OB-1:0] n_kend [NK];
    logic [NK-1:0] r_kfound, n_kfound;

    logic          r_rep_valid;
    logic [OB-1:0] r_rep_start [NK];
    logic [OB-1:0] r_rep_end [NK];
    logic [NK-1:0] r_rep_found;
    logic [OB-1:0] r_rep_nxt;
    logic [1:0]    r_rep_cause;
    logic [1:0]    rep_cause;

    logic          r_out_valid;
    logic [NK-1:0] r_out_found;
    logic [31:0]   r_out_offset [NK];
    logic [31:0]   r_out_length [NK];
    logic [1:0]    r_out_cause;

    logic in_acc, rep_adv;
    logic [OB-1:0] nxt;
    logic [4:0]    hdr_idx_nx;
    logic [63:0]   hdr_decl;
    logic [31:0]   hdr_type;
    logic [63:0]   open_len;
    logic          open_runs;
    logic [OB-1:0] open_sum;
    logic [OB-1:0] open_decl;
    logic          uuid_ok;
    logic [2:0]    uuid_hit;
    logic [2:0]    flags_nx;

    assign rep_adv    = r_rep_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_rep_valid || rep_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign nxt = (r_byte_pos == jp2bms_pkg::POS_MAX) ? jp2bms_pkg::POS_MAX
                                                     : r_byte_pos + OB'(1);
    assign hdr_idx_nx = r_hdr_idx + 5'd1;

    always_comb begin
        if (r_hdr_idx inside {5'd0, 5'd8}) begin
            hdr_decl = {56'd0, i_data_byte};
        end else if (r_hdr_idx inside {[5'd1:5'd3], [5'd9:5'd31]}) begin
            hdr_decl = {r_decl[55:0], i_data_byte};
        end else begin
            hdr_decl = r_decl;
        end
        if (r_hdr_idx inside {[5'd4:5'd7]}) begin
            hdr_type = {r_type[23:0], i_data_byte};
        end else begin
            hdr_type = r_type;
        end
    end

    assign open_len  = (hdr_idx_nx == 5'd8) ? {32'd0, hdr_decl[31:0]} : hdr_decl;
    assign open_sum  = r_box_start + open_len[OB-1:0];
    assign open_runs = ((hdr_idx_nx == 5'd8) && (hdr_decl[31:0] == 32'd0))
                    || (r_box_start == jp2bms_pkg::POS_MAX)
                    || (open_len >= 64'(jp2bms_pkg::POS_MAX - r_box_start));
    assign open_decl = open_runs ? jp2bms_pkg::POS_MAX : open_sum;
    assign uuid_ok   = open_runs
                    || ({1'b0, open_decl} >= ({1'b0, nxt} + (OB+1)'(16)));

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            uuid_hit[j] = (jp2bms_pkg::uuid_byte(2'(j), r_hdr_idx[3:0]) == i_data_byte);
        end
    end
    assign flags_nx = r_flags & uuid_hit;

    always_comb begin
        n_phase     = r_phase;
        n_cause     = r_cause;
        n_byte_pos  = r_byte_pos;
        n_box_start = r_box_start;
        n_hdr_idx   = r_hdr_idx;
        n_decl      = r_decl;
        n_type      = r_type;
        n_runs      = r_runs;
        n_flags     = r_flags;
        n_kstart    = r_kstart;
        n_kend      = r_kend;
        n_kfound    = r_kfound;
        rep_cause   = jp2bms_pkg::CAUSE_CLEAN;

        if (in_acc) begin
            n_byte_pos = nxt;
            case (r_phase)
                jp2bms_pkg::PH_HEADER: begin
                    n_hdr_idx = hdr_idx_nx;
                    n_decl    = hdr_decl;
                    n_type    = hdr_type;
                    if (r_hdr_idx == 5'd0) begin
                        n_box_start = r_byte_pos;
                    end
                    if ((hdr_idx_nx == 5'd8 && hdr_decl[31:0] != 32'd1
                            && (hdr_decl[31:0] == 32'd0 || hdr_decl[31:0] >= 32'd8))
                        || (hdr_idx_nx >= 5'd16 && hdr_decl >= 64'd16)) begin
                        n_runs    = open_runs;
                        n_decl    = 64'(open_decl);
                        n_hdr_idx = 5'd0;
                        if (hdr_type == jp2bms_pkg::TYPE_XML) begin
                            n_kfound[jp2bms_pkg::K_XML] = 1'b1;
                            n_kstart[jp2bms_pkg::K_XML] = nxt;
                            n_kend[jp2bms_pkg::K_XML]   = open_decl;
                        end
                        if (hdr_type == jp2bms_pkg::TYPE_UUID && uuid_ok) begin
                            n_flags = 3'b111;
                            n_phase = jp2bms_pkg::PH_UUID;
                        end else if (!open_runs && open_decl <= nxt) begin
                            n_phase = jp2bms_pkg::PH_HEADER;
                        end else begin
                            n_phase = jp2bms_pkg::PH_PAYLOAD;
                        end
                    end else if ((hdr_idx_nx == 5'd8 && hdr_decl[31:0] != 32'd1)
                                 || hdr_idx_nx >= 5'd16) begin
                        n_cause = jp2bms_pkg::CAUSE_SHORT;
                        n_phase = jp2bms_pkg::PH_STOPPED;
                    end
                end
                jp2bms_pkg::PH_PAYLOAD: begin
                    if (!r_runs && r_decl <= 64'(nxt)) begin
                        n_phase   = jp2bms_pkg::PH_HEADER;
                        n_hdr_idx = 5'd0;
                    end
                end
                jp2bms_pkg::PH_UUID: begin
                    n_flags   = flags_nx;
                    n_hdr_idx = hdr_idx_nx;
                    if (hdr_idx_nx == 5'd16) begin
                        if (flags_nx[0]) begin
                            n_kfound[jp2bms_pkg::K_XMP] = 1'b1;
                            n_kstart[jp2bms_pkg::K_XMP] = nxt;
                            n_kend[jp2bms_pkg::K_XMP]   = r_decl[OB-1:0];
                        end else if (flags_nx[2:1] != 2'b00) begin
                            n_kfound[jp2bms_pkg::K_EXIF] = 1'b1;
                            n_kstart[jp2bms_pkg::K_EXIF] = nxt;
                            n_kend[jp2bms_pkg::K_EXIF]   = r_decl[OB-1:0];
                        end
                        n_hdr_idx = 5'd0;
                        if (!r_runs && r_decl <= 64'(nxt)) begin
                            n_phase = jp2bms_pkg::PH_HEADER;
                        end else begin
                            n_phase = jp2bms_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (n_phase == jp2bms_pkg::PH_STOPPED) begin
                rep_cause = n_cause;
            end else if (n_phase == jp2bms_pkg::PH_HEADER && n_hdr_idx != 5'd0) begin
                rep_cause = jp2bms_pkg::CAUSE_CUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jp2bms_pkg::PH_HEADER;
            r_cause     <= jp2bms_pkg::CAUSE_CLEAN;
            r_byte_pos  <= '0;
            r_box_start <= '0;
            r_hdr_idx   <= '0;
            r_decl      <= '0;
            r_type      <= '0;
            r_runs      <= 1'b0;
            r_flags     <= 3'b111;
            r_kfound    <= '0;
            for (int k = 0; k < NK; k++) begin
                r_kstart[k] <= '0;
                r_kend[k]   <= '0;
            end
        end else if (in_acc && i_last_byte) begin
            r_phase     <= jp2bms_pkg::PH_HEADER;
            r_cause     <= jp2bms_pkg::CAUSE_CLEAN;
            r_byte_pos  <= '0;
            r_box_start <= '0;
            r_hdr_idx   <= '0;
            r_decl      <= '0;
            r_type      <= '0;
            r_runs      <= 1'b0;
            r_flags     <= 3'b111;
            r_kfound    <= '0;
            for (int k = 0; k < NK; k++) begin
                r_kstart[k] <= '0;
                r_kend[k]   <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_cause     <= n_cause;
            r_byte_pos  <= n_byte_pos;
            r_box_start <= n_box_start;
            r_hdr_idx   <= n_hdr_idx;
            r_decl      <= n_decl;
            r_type      <= n_type;
            r_runs      <= n_runs;
            r_flags     <= n_flags;
            r_kfound    <= n_kfound;
            r_kstart    <= n_kstart;
            r_kend      <= n_kend;
        end
    end

    // Stage the report of the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_rep_valid <= 1'b1;
        end else if (rep_adv) begin
            r_rep_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_rep_found <= n_kfound;
            r_rep_start <= n_kstart;
            r_rep_end   <= n_kend;
            r_rep_nxt   <= nxt;
            r_rep_cause <= rep_cause;
        end
    end

    // Clamp to the stream end and form lengths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rep_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rep_adv) begin
            for (int k = 0; k < NK; k++) begin
                logic [OB-1:0] end_c;
                end_c = (r_rep_end[k] < r_rep_nxt) ? r_rep_end[k] : r_rep_nxt;
                r_out_found[k]  <= r_rep_found[k];
                r_out_offset[k] <= r_rep_found[k] ? 32'(r_rep_start[k]) : 32'd0;
                r_out_length[k] <= (r_rep_found[k] && end_c > r_rep_start[k])
                                   ? 32'(end_c - r_rep_start[k]) : 32'd0;
            end
            r_out_cause <= r_rep_cause;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_xml_found   = r_out_found[jp2bms_pkg::K_XML];
    assign o_xml_offset  = r_out_offset[jp2bms_pkg::K_XML];
    assign o_xml_length  = r_out_length[jp2bms_pkg::K_XML];
    assign o_xmp_found   = r_out_found[jp2bms_pkg::K_XMP];
    assign o_xmp_offset  = r_out_offset[jp2bms_pkg::K_XMP];
    assign o_xmp_length  = r_out_length[jp2bms_pkg::K_XMP];
    assign o_exif_found  = r_out_found[jp2bms_pkg::K_EXIF];
    assign o_exif_offset = r_out_offset[jp2bms_pkg::K_EXIF];
    assign o_exif_length = r_out_length[jp2bms_pkg::K_EXIF];
    assign o_stop_cause  = r_out_cause;

`include "assert_macros.svh"

    `AM_ASSERT_SAME(a_phase_onehot, 1'b1, $onehot(r_phase), "parse phase not one-hot")
    `AM_ASSERT_NEXT(a_restart, in_acc && i_last_byte,
        r_phase == jp2bms_pkg::PH_HEADER && r_byte_pos == '0 && r_rep_valid,
        "scanner did not restart after the final byte")
    `AM_ASSERT_SAME(a_stall, r_rep_valid && r_out_valid && !i_out_ready, !o_in_ready,
        "input taken while both report stages are full")
    `AM_ASSERT_SAME(a_xml_len, o_out_valid && !o_xml_found, o_xml_length == 32'd0,
        "xml length reported without an xml box")

endmodule

`default_nettype wire
